[rtl/core/nps_pkg.sv]
package nps_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Coordinate and distance widths
  localparam int COORD_W = 18;
  localparam int MAG_W   = COORD_W;          // |a - b| of two signed coords
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = 37;
  localparam int SUM_W   = DIST_W + 1;       // room to detect saturation

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Request codes
  typedef logic [1:0] req_t;
  localparam req_t REQ_CLEAR = 2'd0;
  localparam req_t REQ_LOAD  = 2'd1;
  localparam req_t REQ_QUERY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Tag that travels with each scanned entry through the distance pipeline
  typedef struct packed {
    logic             v;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

[rtl/core/nearest_point_search.sv]
// Nearest-point search over a table of up to TABLE_DEPTH 2-D points.
//
// Input channel: an item is taken when start is high and busy is low.
//   in_req_type selects clear (empty the table, drop the overflow flag),
//   load (append in_x_coord/in_y_coord, or flag overflow when full) or
//   query (find the nearest stored point). Code 3 is ignored.
// Result channel: a query gives one item, shown for exactly one cycle while
//   out_valid is high. Clear and load give none. The receiver cannot stall.
// Timing: busy stays low for clear and load. A query on an empty
//   table shows its result in the next cycle. A query on stored points
//   keeps busy high while the shared distance pipeline (registered
//   table read, difference, square, add/compare) takes one entry per cycle
//   and then drains. The result appears as busy drops.
// Ties go to the lowest index. Squared distance is unsigned Q37.0, saturated.
// Reset: synchronous, active low. Count, overflow flag and sequencer clear;
//   table contents are kept and never used beyond the stored count.
module nearest_point_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  nps_pkg::req_t                in_req_type,
  input  logic signed [nps_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [nps_pkg::COORD_W-1:0] in_y_coord,
  output logic                         busy,
  output logic                         out_valid,
  output logic [nps_pkg::IDX_W-1:0]    out_nearest_index,
  output logic [nps_pkg::DIST_W-1:0]   out_best_dist_sq,
  output logic                         out_table_empty,
  output logic                         out_overflowed,
  output logic [nps_pkg::CNT_W-1:0]    out_stored_count
);
  import nps_pkg::*;

  // Control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Query point
  logic signed [COORD_W-1:0] qx_r, qy_r;

  // Point table
  logic [2*COORD_W-1:0] point_mem [TABLE_DEPTH];
  logic [2*COORD_W-1:0] rd_data_r;

  // Pipeline tags and data
  tag_t             s0_tag;
  tag_t             s1_tag_r, s2_tag_r, s3_tag_r;
  logic [MAG_W-1:0] mag_x_r, mag_y_r;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r;

  // Running best
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;

  logic                accept;
  logic                wr_en;
  logic                query_empty;
  logic                done;
  logic                has_room;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic signed [COORD_W:0]   abs_x, abs_y;
  logic [SUM_W-1:0]    sum;
  logic [DIST_W-1:0]   cand_dist;
  logic                take;
  logic [IDX_W-1:0]    best_idx_upd;
  logic [DIST_W-1:0]   best_dist_upd;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && !busy;
  assign has_room  = (count_r < CNT_W'(TABLE_DEPTH));
  assign wr_en     = accept && (in_req_type == REQ_LOAD) && has_room;
  assign query_empty = accept && (in_req_type == REQ_QUERY) && (count_r == '0);

  // Entry issued to the table read this cycle
  always_comb begin
    s0_tag.v     = (state_r == ST_SCAN);
    s0_tag.first = (scan_pos_r == '0);
    s0_tag.last  = (scan_pos_r == count_r - CNT_W'(1));
    s0_tag.idx   = scan_pos_r[IDX_W-1:0];
  end

  // Sequencer: next state and control updates
  always_comb begin
    state_nxt     = state_r;
    scan_pos_nxt  = scan_pos_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            REQ_LOAD: begin
              if (has_room) count_nxt = count_r + CNT_W'(1);
              else          ovf_nxt   = 1'b1;
            end
            REQ_QUERY: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                ovf_nxt       = 1'b0;
              end else begin
                state_nxt    = ST_SCAN;
                scan_pos_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_pos_nxt = scan_pos_r + CNT_W'(1);
        if (s0_tag.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          ovf_nxt       = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_pos_r  <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_pos_r  <= scan_pos_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      s1_tag_r    <= s0_tag;
      s2_tag_r    <= s1_tag_r;
      s3_tag_r    <= s2_tag_r;
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_QUERY)) begin
      qx_r <= in_x_coord;
      qy_r <= in_y_coord;
    end
  end

  // Table: one write port for loads, registered read for the scan
  always_ff @(posedge clk) begin
    if (wr_en) point_mem[count_r[IDX_W-1:0]] <= {in_x_coord, in_y_coord};
    rd_data_r <= point_mem[scan_pos_r[IDX_W-1:0]];
  end

  // Stage 2: coordinate differences and magnitudes
  assign rd_x   = rd_data_r[2*COORD_W-1:COORD_W];
  assign rd_y   = rd_data_r[COORD_W-1:0];
  assign diff_x = {qx_r[COORD_W-1], qx_r} - {rd_x[COORD_W-1], rd_x};
  assign diff_y = {qy_r[COORD_W-1], qy_r} - {rd_y[COORD_W-1], rd_y};
  assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
  assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

  always_ff @(posedge clk) begin
    mag_x_r <= abs_x[MAG_W-1:0];
    mag_y_r <= abs_y[MAG_W-1:0];
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    sq_x_r <= mag_x_r * mag_x_r;
    sq_y_r <= mag_y_r * mag_y_r;
  end

  // Stage 4: saturated sum and compare against the running best
  assign sum       = SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
  assign cand_dist = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  assign take      = s3_tag_r.first || (cand_dist < best_dist_r);
  assign done      = s3_tag_r.v && s3_tag_r.last;

  always_comb begin
    best_idx_upd  = best_idx_r;
    best_dist_upd = best_dist_r;
    if (s3_tag_r.v && take) begin
      best_idx_upd  = s3_tag_r.idx;
      best_dist_upd = cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_upd;
    best_dist_r <= best_dist_upd;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (query_empty) begin
      out_nearest_index <= '0;
      out_best_dist_sq  <= DIST_MAX;
      out_table_empty   <= 1'b1;
      out_overflowed    <= ovf_r;
      out_stored_count  <= count_r;
    end else if (done) begin
      out_nearest_index <= best_idx_upd;
      out_best_dist_sq  <= best_dist_upd;
      out_table_empty   <= 1'b0;
      out_overflowed    <= ovf_r;
      out_stored_count  <= count_r;
    end
  end

endmodule

[rtl/core/nps_checker.sv]
module nps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input nps_pkg::req_t                in_req_type,
  input logic                         busy,
  input logic                         out_valid,
  input logic [nps_pkg::IDX_W-1:0]    out_nearest_index,
  input logic [nps_pkg::DIST_W-1:0]   out_best_dist_sq,
  input logic                         out_table_empty,
  input logic [nps_pkg::CNT_W-1:0]    out_stored_count
);
  import nps_pkg::*;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A query either starts a scan or answers at once
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_QUERY) |=> busy || out_valid)
    else $error("query item neither scanned nor answered");

  // Empty-table result is fully defined
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |->
      (out_stored_count == '0) && (out_nearest_index == '0) &&
      (out_best_dist_sq == DIST_MAX))
    else $error("bad empty-table result");

  // Nearest index lies inside the stored part of the table
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_table_empty |->
      (CNT_W'(out_nearest_index) < out_stored_count))
    else $error("nearest index beyond stored count");

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);
